// File: rtl/core/greedy_density_knapsack_macros.svh
// assertion macros used by the top-level knapsack rtl file
// no dependencies
`ifndef GREEDY_DENSITY_KNAPSACK_MACROS_SVH
`define GREEDY_DENSITY_KNAPSACK_MACROS_SVH

// property must hold on every clock edge out of reset
`define GDK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a condition implies another in the next cycle
`define GDK_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/gdk_pkg.sv
// types and constants for the greedy density knapsack
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gdk_pkg;
    localparam int unsigned CapBits    = 24;
    localparam int unsigned ProfitBits = 16;
    localparam int unsigned ShareBits  = 17;
    localparam int unsigned TotalBits  = 38;
    localparam int unsigned NumBits    = 7;
    localparam int unsigned InWeightBits = 16;

    localparam logic CfgCapacity = 1'b0;
    localparam logic CfgFracMode = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_FILL,
        ST_DIV,
        ST_EMIT
    } t_state;

    // control handed from sequencer to each cell
    typedef struct packed {
        logic insert;   // new item presented to the chain
        logic shift;    // rotate contents toward cell 0
        logic clear;    // invalidate all cells
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: rtl/core/gdk_cell.sv
// one sort cell of the density chain: holds one item, compares with the
// incoming item by cross-multiplication; uses gdk_pkg
`timescale 1ns / 1ps
`default_nettype none
module gdk_cell #(
    parameter int unsigned WB = 16,
    parameter int unsigned NB = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gdk_pkg::t_cell_ctl            i_ctl,
    input  wire logic [WB-1:0]                 i_new_w,
    input  wire logic [gdk_pkg::ProfitBits-1:0] i_new_p,
    input  wire logic [NB-1:0]                 i_new_n,
    // from the left neighbor (toward cell 0)
    input  wire logic                          i_left_take,
    input  wire logic                          i_left_v,
    input  wire logic [WB-1:0]                 i_left_w,
    input  wire logic [gdk_pkg::ProfitBits-1:0] i_left_p,
    input  wire logic [NB-1:0]                 i_left_n,
    // from the right neighbor, used when rotating out
    input  wire logic                          i_right_v,
    input  wire logic [WB-1:0]                 i_right_w,
    input  wire logic [gdk_pkg::ProfitBits-1:0] i_right_p,
    input  wire logic [NB-1:0]                 i_right_n,
    output logic                               o_take,
    output logic                               o_v,
    output logic [WB-1:0]                      o_w,
    output logic [gdk_pkg::ProfitBits-1:0]     o_p,
    output logic [NB-1:0]                      o_n
);
    localparam int unsigned MB = WB + gdk_pkg::ProfitBits;

    logic r_v;
    logic [WB-1:0] r_w;
    logic [gdk_pkg::ProfitBits-1:0] r_p;
    logic [NB-1:0] r_n;
    logic [MB-1:0] lhs, rhs;
    logic denser;

    // new item goes before this one when p_new*w_here > p_here*w_new
    assign lhs = MB'(i_new_p) * MB'(r_w);
    assign rhs = MB'(r_p) * MB'(i_new_w);
    assign denser = lhs > rhs;
    assign o_take = !r_v || denser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_v <= 1'b0;
        end else if (i_ctl.shift) begin
            r_v <= i_right_v;
            r_w <= i_right_w;
            r_p <= i_right_p;
            r_n <= i_right_n;
        end else if (i_ctl.insert && o_take) begin
            if (i_left_take) begin
                r_w <= i_left_w;
                r_p <= i_left_p;
                r_n <= i_left_n;
                r_v <= i_left_v;
            end else begin
                r_w <= i_new_w;
                r_p <= i_new_p;
                r_n <= i_new_n;
                r_v <= 1'b1;
            end
        end
    end

    assign o_v = r_v;
    assign o_w = r_w;
    assign o_p = r_p;
    assign o_n = r_n;
endmodule
`default_nettype wire

// File: rtl/core/gdk_divider.sv
// restoring divider: remaining * 65536 / weight, one quotient bit per cycle
// uses gdk_pkg
`timescale 1ns / 1ps
`default_nettype none
module gdk_divider #(
    parameter int unsigned WB = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [gdk_pkg::CapBits-1:0]  i_rem,
    input  wire logic [WB-1:0]                i_div,
    output logic                              o_done,
    output logic [gdk_pkg::ShareBits-1:0]     o_quo
);
    // remaining < weight so the quotient fits in 16 bits
    localparam int unsigned RB = WB + 1;
    logic [RB-1:0] r_acc;
    logic [WB-1:0] r_d;
    logic [gdk_pkg::CapBits+15:0] r_num;
    logic [gdk_pkg::ShareBits-1:0] r_q;
    logic [5:0] r_cnt;
    logic r_busy, r_done;
    logic [RB-1:0] trial;

    assign trial = {r_acc[RB-2:0], r_num[gdk_pkg::CapBits+15]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_d    <= i_div;
                r_num  <= {i_rem, 16'd0};
                r_q    <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (trial >= RB'(r_d)) begin
                    r_acc <= trial - RB'(r_d);
                    r_q   <= {r_q[gdk_pkg::ShareBits-2:0], 1'b1};
                end else begin
                    r_acc <= trial;
                    r_q   <= {r_q[gdk_pkg::ShareBits-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(gdk_pkg::CapBits + 15)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

// File: rtl/core/greedy_density_knapsack.sv
// Greedy knapsack by profit density. Items stream into a chain of
// MAX_ITEMS sort cells that keep them in descending profit/weight order
// (cross-multiplied compare, ties keep arrival order); after each accepted
// item a settle cycle holds off input. After the item marked last a setup
// state loads the capacity, then the chain is rotated toward cell 0 once
// per cycle through one full turn of the ring, filling capacity greedily
// from cell 0 and bringing the ring back into place. In fractional mode
// with a partly taken item a 40-step bit-serial divider then runs. Results
// follow: whole-item mode sends them in density order, one per cycle while
// the receiver keeps up; fractional mode sends them in arrival order,
// finding each by rotating the chain until it reaches cell 0. Totals ride
// on the last result. Input is held off from the last item until the
// final result is taken and the chain is cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_density_knapsack_macros.svh"
module greedy_density_knapsack #(
    parameter int unsigned MAX_ITEMS   = 64,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] item_weight, [31:16] item_profit
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,   // last_item
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] item_number, [23:7] taken_fraction, [39:24] result_profit,
    // [63:40] total_weight, [101:64] total_profit, [103:102] zero
    output logic [103:0]     m_axis_tdata,
    output logic             m_axis_tlast,   // last_result
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    localparam int unsigned NB = $clog2(MAX_ITEMS);
    localparam int unsigned CB = $clog2(MAX_ITEMS + 1);
    localparam int unsigned WB = WEIGHT_BITS;
    localparam int unsigned PB = gdk_pkg::ProfitBits;
    localparam int unsigned KB = gdk_pkg::CapBits;
    localparam int unsigned XB = (WB > KB) ? WB : KB;
    localparam int unsigned IB = (WB < gdk_pkg::InWeightBits) ? WB : gdk_pkg::InWeightBits;
    localparam int unsigned FB = PB + gdk_pkg::ShareBits;

    gdk_pkg::t_state r_state, n_state;
    logic [KB-1:0] r_cap;
    logic r_frac;
    logic [CB-1:0] r_count, n_count;
    logic [CB-1:0] r_idx, n_idx;     // cells rotated past so far
    logic [CB-1:0] r_pos, n_pos;     // density rank of the item in cell 0
    logic [CB-1:0] r_emit, n_emit;   // results sent
    logic [KB-1:0] r_rem, n_rem;
    logic r_stop, n_stop;
    logic [CB-1:0] r_stop_k, n_stop_k;   // density rank of the stop item
    logic [gdk_pkg::ShareBits-1:0] r_stop_share, n_stop_share;
    logic [gdk_pkg::TotalBits-1:0] r_tot, n_tot;
    logic r_settle, n_settle;
    logic r_ovalid, n_ovalid;
    logic [103:0] r_odata, n_odata;
    logic r_olast, n_olast;
    logic [KB-1:0] r_stop_wrem;
    logic [WB-1:0] r_stop_w;
    logic [PB-1:0] r_stop_p;
    gdk_pkg::t_cell_ctl ctl;
    logic div_start, div_done;
    logic [gdk_pkg::ShareBits-1:0] div_q;

    logic [WB-1:0] in_w;
    logic [PB-1:0] in_p;
    logic          acc;

    logic          c_take [MAX_ITEMS];
    logic          c_v    [MAX_ITEMS];
    logic [WB-1:0] c_w    [MAX_ITEMS];
    logic [PB-1:0] c_p    [MAX_ITEMS];
    logic [NB-1:0] c_n    [MAX_ITEMS];

    logic [XB-1:0] w0x, remx;
    logic fits;
    logic stop_now;
    logic [gdk_pkg::ShareBits-1:0] sh0;
    logic [FB-1:0] frac_pp;
    logic hit;
    logic [CB-1:0] pos_next;

    assign in_w = WB'(s_axis_tdata[IB-1:0]);
    assign in_p = s_axis_tdata[31:16];
    assign o_cfg_ready = 1'b1;

    // settle cycle after each accepted item holds off the next item
    assign s_axis_tready = (r_state == gdk_pkg::ST_LOAD) && !r_settle;
    assign acc = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            logic          lt, lv, rv;
            logic [WB-1:0] lw, rw;
            logic [PB-1:0] lp, rp;
            logic [NB-1:0] ln, rn;
            if (g == 0) begin : g_first
                assign lt = 1'b0;
                assign lv = 1'b0;
                assign lw = '0;
                assign lp = '0;
                assign ln = '0;
            end else begin : g_mid
                assign lt = c_take[g-1];
                assign lv = c_v[g-1];
                assign lw = c_w[g-1];
                assign lp = c_p[g-1];
                assign ln = c_n[g-1];
            end
            // rotation wraps cell 0 to the end so contents survive a full pass
            if (g == MAX_ITEMS - 1) begin : g_last
                assign rv = c_v[0];
                assign rw = c_w[0];
                assign rp = c_p[0];
                assign rn = c_n[0];
            end else begin : g_inner
                assign rv = c_v[g+1];
                assign rw = c_w[g+1];
                assign rp = c_p[g+1];
                assign rn = c_n[g+1];
            end
            gdk_cell #(.WB(WB), .NB(NB)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
                .i_new_w(in_w), .i_new_p(in_p), .i_new_n(r_count[NB-1:0]),
                .i_left_take(lt), .i_left_v(lv), .i_left_w(lw),
                .i_left_p(lp), .i_left_n(ln),
                .i_right_v(rv), .i_right_w(rw), .i_right_p(rp), .i_right_n(rn),
                .o_take(c_take[g]), .o_v(c_v[g]), .o_w(c_w[g]),
                .o_p(c_p[g]), .o_n(c_n[g])
            );
        end
    endgenerate

    gdk_divider #(.WB(WB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_rem(r_stop_wrem), .i_div(r_stop_w),
        .o_done(div_done), .o_quo(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_frac <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gdk_pkg::CfgCapacity: r_cap  <= i_cfg_data;
                gdk_pkg::CfgFracMode: r_frac <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gdk_pkg::ST_LOAD;
            r_count    <= '0;
            r_settle   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_pos      <= '0;
            r_emit     <= '0;
            r_stop     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_settle   <= n_settle;
            r_ovalid   <= n_ovalid;
            r_idx      <= n_idx;
            r_pos      <= n_pos;
            r_emit     <= n_emit;
            r_stop     <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_stop_k     <= n_stop_k;
        r_stop_share <= n_stop_share;
        r_tot        <= n_tot;
        r_odata      <= n_odata;
        r_olast      <= n_olast;
        if (stop_now) begin
            r_stop_wrem <= r_rem;
            r_stop_w    <= c_w[0];
            r_stop_p    <= c_p[0];
        end
    end

    assign w0x  = XB'(c_w[0]);
    assign remx = XB'(r_rem);
    assign fits = w0x <= remx;
    assign stop_now = (r_state == gdk_pkg::ST_FILL) && (r_idx < r_count) && !r_stop && !fits;
    assign frac_pp = FB'(r_stop_p) * FB'(div_q);
    assign pos_next = (r_pos == CB'(MAX_ITEMS - 1)) ? '0 : r_pos + CB'(1);

    // share of the item sitting in cell 0 during emission
    always_comb begin
        if (r_stop && r_pos == r_stop_k) begin
            sh0 = r_stop_share;
        end else if (r_stop && r_pos > r_stop_k) begin
            sh0 = '0;
        end else begin
            sh0 = {1'b1, 16'd0};
        end
    end
    assign hit = r_frac ? (CB'(c_n[0]) == r_emit) : 1'b1;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_settle     = 1'b0;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_emit       = r_emit;
        n_rem        = r_rem;
        n_stop       = r_stop;
        n_stop_k     = r_stop_k;
        n_stop_share = r_stop_share;
        n_tot        = r_tot;
        n_ovalid     = r_ovalid && !m_axis_tready;
        n_odata      = r_odata;
        n_olast      = r_olast;
        ctl          = '0;
        div_start    = 1'b0;
        case (r_state)
            gdk_pkg::ST_LOAD: begin
                if (acc) begin
                    n_settle = 1'b1;
                    if (r_count < CB'(MAX_ITEMS)) begin
                        ctl.insert = 1'b1;
                        n_count = r_count + CB'(1);
                    end
                    if (s_axis_tlast) begin
                        n_state = gdk_pkg::ST_SETTLE;
                    end
                end
            end
            gdk_pkg::ST_SETTLE: begin
                n_rem  = r_cap;
                n_idx  = '0;
                n_stop = 1'b0;
                n_stop_k = '0;
                n_tot  = '0;
                n_stop_share = '0;
                n_state = (r_count == '0) ? gdk_pkg::ST_LOAD : gdk_pkg::ST_FILL;
            end
            gdk_pkg::ST_FILL: begin
                // cell 0 holds the densest remaining item; rotate once per cycle
                if (r_idx < r_count) begin
                    ctl.shift = 1'b1;
                    n_idx = r_idx + CB'(1);
                    if (!r_stop) begin
                        if (fits) begin
                            n_rem = r_rem - KB'(c_w[0]);
                            n_tot = r_tot + gdk_pkg::TotalBits'({c_p[0], 16'd0});
                        end else begin
                            n_stop   = 1'b1;
                            n_stop_k = r_idx;
                        end
                    end
                end else begin
                    // rotate the rest of the ring back into place
                    if (r_idx < CB'(MAX_ITEMS)) begin
                        ctl.shift = 1'b1;
                        n_idx = r_idx + CB'(1);
                    end else begin
                        n_idx = '0;
                        n_pos = '0;
                        n_emit = '0;
                        if (r_stop && r_frac) begin
                            div_start = 1'b1;
                            n_state = gdk_pkg::ST_DIV;
                        end else begin
                            n_state = gdk_pkg::ST_EMIT;
                        end
                    end
                end
            end
            gdk_pkg::ST_DIV: begin
                if (div_done) begin
                    n_stop_share = div_q;
                    n_tot = r_tot + gdk_pkg::TotalBits'(frac_pp);
                    n_state = gdk_pkg::ST_EMIT;
                end
            end
            gdk_pkg::ST_EMIT: begin
                if (r_emit < r_count) begin
                    if (c_v[0] && hit) begin
                        if (!n_ovalid) begin
                            n_ovalid = 1'b1;
                            n_emit   = r_emit + CB'(1);
                            n_olast  = (r_emit + CB'(1) == r_count);
                            n_odata  = '0;
                            n_odata[6:0]   = gdk_pkg::NumBits'(c_n[0]) + 7'd1;
                            n_odata[23:7]  = sh0;
                            n_odata[39:24] = c_p[0];
                            if (r_emit + CB'(1) == r_count) begin
                                n_odata[63:40]  = r_cap - r_rem;
                                n_odata[101:64] = r_tot;
                            end
                            ctl.shift = 1'b1;
                            n_pos = pos_next;
                        end
                    end else begin
                        ctl.shift = 1'b1;
                        n_pos = pos_next;
                    end
                end else if (!r_ovalid) begin
                    ctl.clear = 1'b1;
                    n_count = '0;
                    n_state = gdk_pkg::ST_LOAD;
                end
            end
            default: n_state = gdk_pkg::ST_LOAD;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    `GDK_ASSERT(a_no_in_while_busy, i_clk, i_rst_n, !(s_axis_tready && r_state != gdk_pkg::ST_LOAD), "input ready outside load")
    `GDK_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CB'(MAX_ITEMS), "count overflow")
    `GDK_ASSERT_NEXT(a_settle, i_clk, i_rst_n, acc, !s_axis_tready, "two-cycle rate broken")
    `GDK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
endmodule
`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for greedy_density_knapsack: streams item sets, predicts results
// depends on gdk_pkg and the greedy_density_knapsack rtl
`timescale 1ns / 1ps

class knapsack_scoreboard;
    bit [23:0] capacity;
    bit        frac_mode;
    bit [15:0] set_weight[$];
    bit [15:0] set_profit[$];
    logic [104:0] expected_q[$];   // {tlast, tdata}
    int errors;

    function int pending();
        return expected_q.size();
    endfunction

    function bit denser(int a, int b);
        return longint'(set_profit[a]) * longint'(set_weight[b]) >
               longint'(set_profit[b]) * longint'(set_weight[a]);
    endfunction

    // orders the set by density, fills greedily and queues one result per item of the set
    function void fill_knapsack();
        int order[$];
        int n, pos, k, i;
        bit [16:0] share[64];
        longint rem, total;
        bit stopped;
        logic [103:0] d;
        n = set_weight.size();
        for (i = 0; i < n; i++) begin
            pos = order.size();
            while (pos > 0 && denser(i, order[pos - 1])) pos--;
            order.insert(pos, i);
        end
        rem = capacity;
        total = 0;
        stopped = 0;
        for (k = 0; k < n; k++) begin
            i = order[k];
            share[i] = 0;
            if (stopped) continue;
            if (set_weight[i] > rem) begin
                stopped = 1;
                if (frac_mode) share[i] = 17'((rem << 16) / set_weight[i]);
            end else begin
                share[i] = 17'h10000;
                rem -= set_weight[i];
            end
        end
        for (i = 0; i < n; i++) total += longint'(set_profit[i]) * longint'(share[i]);
        for (k = 0; k < n; k++) begin
            i = frac_mode ? k : order[k];
            d = '0;
            d[6:0]   = 7'(i + 1);
            d[23:7]  = share[i];
            d[39:24] = set_profit[i];
            if (k == n - 1) begin
                d[63:40]  = capacity - rem[23:0];
                d[101:64] = total[37:0];
            end
            expected_q.push_back({k == n - 1, d});
        end
        set_weight.delete();
        set_profit.delete();
    endfunction

    function void note_item(bit [15:0] w, bit [15:0] p, bit last);
        if (set_weight.size() < 64) begin
            set_weight.push_back(w);
            set_profit.push_back(p);
        end
        if (last) fill_knapsack();
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(logic [103:0] d, logic l);
        logic [104:0] e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, {l, d});
            errors++;
            return;
        end
        e = expected_q.pop_front();
        compare_field("item_number", e[6:0], d[6:0]);
        compare_field("taken_fraction", e[23:7], d[23:7]);
        compare_field("result_profit", e[39:24], d[39:24]);
        compare_field("total_weight", e[63:40], d[63:40]);
        compare_field("total_profit", e[101:64], d[101:64]);
        compare_field("pad", e[103:102], d[103:102]);
        compare_field("last_result", e[104], l);
    endfunction
endclass

module tb_top;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic         i_cfg_index = 0;
    logic [23:0]  i_cfg_data = '0;

    knapsack_scoreboard sb = new();
    int burst_left = 0;
    int hold_request = 0;
    int items_sent = 0;

    greedy_density_knapsack DUT (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: alternating free-flowing and random stall windows, plus long holds on request
    initial begin : receiver
        int hold, phase;
        hold = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            phase++;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 0;
            end else if ((phase / 50) % 2 == 0) begin
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_item(bit [15:0] w, bit [15:0] p, bit last);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {p, w};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(w, p, last);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, bit [23:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == gdk_pkg::CfgCapacity) sb.capacity = value;
        else sb.frac_mode = value[0];
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic set_config(bit [23:0] cap, bit mode);
        wait_drained();
        write_reg(gdk_pkg::CfgCapacity, cap);
        write_reg(gdk_pkg::CfgFracMode, {23'd0, mode});
    endtask

    // random set: small weights make the capacity matter, full-range ones toggle every bit
    task automatic send_random_set(int n);
        bit narrow;
        bit [15:0] w;
        narrow = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
            w = narrow ? 16'($urandom_range(1, 300)) : 16'($urandom_range(1, 65535));
            send_item(w, 16'($urandom_range(0, 65535)), i == n - 1);
        end
        stop_sending();
    endtask

    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // weight and profit extremes, equal densities keep arrival order
        set_config(24'hFFFFFF, 1'b1);
        send_item(16'd1, 16'hFFFF, 1'b0);
        send_item(16'hFFFF, 16'd0, 1'b0);
        send_item(16'hFFFF, 16'hFFFF, 1'b0);
        send_item(16'd3, 16'd6, 1'b0);
        send_item(16'd2, 16'd4, 1'b1);
        stop_sending();
        // zero capacity: nothing fits
        set_config(24'd0, 1'b0);
        send_item(16'd5, 16'd7, 1'b0);
        send_item(16'd1, 16'd1, 1'b1);
        stop_sending();
        set_config(24'd0, 1'b1);
        send_item(16'd5, 16'd7, 1'b1);
        stop_sending();
        // partial fill: whole-item stop, then fractional share
        for (int m = 0; m < 2; m++) begin
            set_config(24'd100, 1'(m));
            send_item(16'd60, 16'd60, 1'b0);
            send_item(16'd50, 16'd100, 1'b0);
            send_item(16'd30, 16'd30, 1'b0);
            send_item(16'd20, 16'd40, 1'b1);
            stop_sending();
        end
        // more items than the store holds, last mark on an ignored item
        set_config(24'($urandom_range(500, 4000)), 1'b1);
        send_random_set(66);
        set_config(24'($urandom_range(500, 4000)), 1'b0);
        send_random_set(64);

        for (int s = 0; items_sent < 160; s++) begin
            if (s % 3 == 0) begin
                case ($urandom_range(0, 3))
                    0: set_config(24'd0, 1'($urandom_range(0, 1)));
                    1: set_config(24'hFFFFFF, 1'($urandom_range(0, 1)));
                    2: set_config(24'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)));
                    default: set_config(24'($urandom_range(0, 24'hFFFFFF)),
                                        1'($urandom_range(0, 1)));
                endcase
            end
            if (s == 0) hold_request = 400;
            n = $urandom_range(1, 8);
            send_random_set(n);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: greedy_density_knapsack.f
+incdir+rtl/core
rtl/core/gdk_pkg.sv
rtl/core/gdk_cell.sv
rtl/core/gdk_divider.sv
rtl/core/greedy_density_knapsack.sv
test/tb_top.sv
